### rtl/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
`default_nettype none
package lpfp_pkg;

    localparam int unsigned LENGTH_BYTES_DEF = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [BYTE_W-1:0] FILE_COMMAND_RST = 8'd17;

    localparam logic [KIND_W-1:0] KIND_MSG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MSB_FIRST    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_COMMAND = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } result_t;

endpackage
`default_nettype wire

### rtl/lpfp_core.sv
// Frame parsing state: header assembly, command capture and payload count.
`default_nettype none
module lpfp_core #(
    parameter int unsigned LENGTH_BYTES = lpfp_pkg::LENGTH_BYTES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        msb_first,
    input  wire logic [lpfp_pkg::BYTE_W-1:0] file_command,
    input  wire logic                        in_accept,
    input  wire logic [lpfp_pkg::BYTE_W-1:0] in_byte,
    output      logic                        res_valid,
    output      lpfp_pkg::result_t           res
);

    localparam int unsigned ACC_W   = lpfp_pkg::BYTE_W * LENGTH_BYTES;
    localparam int unsigned PHASE_W = $clog2(LENGTH_BYTES + 2);
    localparam int unsigned IDX_W   = $clog2(LENGTH_BYTES);
    localparam logic [PHASE_W-1:0] PHASE_HDR0 = '0;
    localparam logic [PHASE_W-1:0] PHASE_CMD  = PHASE_W'(LENGTH_BYTES);
    localparam logic [PHASE_W-1:0] PHASE_PAY  = PHASE_W'(LENGTH_BYTES + 1);

    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic [ACC_W-1:0]            length_reg, length_next;
    logic [lpfp_pkg::BYTE_W-1:0] command_reg, command_next;
    logic [ACC_W-1:0]            left_reg, left_next;
    logic                        file_mode_reg, file_mode_next;

    logic [PHASE_W-1:0] phase_eff;
    logic [ACC_W-1:0]   acc_base;
    logic [IDX_W-1:0]   lane_idx;
    logic               pay_last;

    always_comb begin
        phase_eff = (phase_reg > PHASE_PAY) ? PHASE_HDR0 : phase_reg;
        acc_base  = (phase_eff == PHASE_HDR0) ? '0 : length_reg;
        lane_idx  = phase_eff[IDX_W-1:0];
        pay_last  = (left_reg <= ACC_W'(1));

        phase_next     = phase_eff;
        length_next    = length_reg;
        command_next   = command_reg;
        left_next      = left_reg;
        file_mode_next = file_mode_reg;
        res_valid      = 1'b0;
        res.kind       = lpfp_pkg::KIND_MSG;
        res.command    = command_reg;
        res.data_byte  = in_byte;
        res.last       = 1'b0;

        priority if (phase_eff < PHASE_CMD) begin
            if (msb_first) begin
                length_next = {acc_base[ACC_W-lpfp_pkg::BYTE_W-1:0], in_byte};
            end else begin
                length_next = acc_base;
                for (int i = 0; i < LENGTH_BYTES; i++) begin
                    if (lane_idx == IDX_W'(i)) begin
                        length_next[i*lpfp_pkg::BYTE_W +: lpfp_pkg::BYTE_W] =
                            acc_base[i*lpfp_pkg::BYTE_W +: lpfp_pkg::BYTE_W] | in_byte;
                    end
                end
            end
            phase_next = phase_eff + PHASE_W'(1);
        end else if (phase_eff == PHASE_CMD) begin
            command_next = in_byte;
            res.command  = in_byte;
            if (length_reg <= ACC_W'(1)) begin
                // zero or one: no payload, one empty marker
                res_valid      = 1'b1;
                res.kind       = lpfp_pkg::KIND_EMPTY;
                res.data_byte  = '0;
                res.last       = 1'b1;
                left_next      = '0;
                file_mode_next = 1'b0;
                phase_next     = PHASE_HDR0;
            end else begin
                file_mode_next = (in_byte == file_command);
                left_next      = length_reg - ACC_W'(1);
                phase_next     = PHASE_PAY;
            end
        end else begin
            res_valid = 1'b1;
            res.kind  = file_mode_reg ? lpfp_pkg::KIND_FILE : lpfp_pkg::KIND_MSG;
            res.last  = pay_last;
            if (pay_last) begin
                left_next      = '0;
                file_mode_next = 1'b0;
                phase_next     = PHASE_HDR0;
            end else begin
                left_next = left_reg - ACC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_HDR0;
            length_reg    <= '0;
            command_reg   <= '0;
            left_reg      <= '0;
            file_mode_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            command_reg   <= command_next;
            left_reg      <= left_next;
            file_mode_reg <= file_mode_next;
        end
    end

endmodule
`default_nettype wire

### rtl/length_prefixed_frame_parser_unit.sv
// Top level of the length-prefixed frame parser: stream ports, registers, output stage.
// Takes one byte per clock while s_tready is high; the parse state is updated in
// the accepting cycle and any result lands in the output register, which shows it on
// the master side from the next cycle. s_tready stays high while that register is
// empty or being drained, so bytes flow back to back with no gap. A frame is a
// LENGTH_BYTES-byte length (byte order per register 0), a command byte, then length-1
// payload bytes, each delivered as one word; a length of 0 or 1 gives one empty-frame
// word instead. Register 0 is msb_first (reset 1), register 1 file_command (reset 17);
// writes to other indices are dropped. Write registers only while the parser is idle.
`default_nettype none
module length_prefixed_frame_parser_unit #(
    parameter int unsigned LENGTH_BYTES = lpfp_pkg::LENGTH_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [15:0]                      m_tdata,   // [7:0] command, [15:8] data_byte
    output      logic [lpfp_pkg::KIND_W-1:0]      m_tuser,   // [1:0] kind
    output      logic                             m_tlast,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [lpfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    logic                        msb_first_reg;
    logic [lpfp_pkg::BYTE_W-1:0] file_command_reg;
    logic                        m_valid_reg, m_valid_next;
    lpfp_pkg::result_t           m_res_reg;
    logic                        in_accept;
    logic                        res_valid;
    lpfp_pkg::result_t           res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    lpfp_core #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .msb_first    (msb_first_reg),
        .file_command (file_command_reg),
        .in_accept    (in_accept),
        .in_byte      (s_tdata),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msb_first_reg    <= 1'b1;
            file_command_reg <= lpfp_pkg::FILE_COMMAND_RST;
        end else if (cfg_valid) begin
            if (cfg_index == lpfp_pkg::CFG_MSB_FIRST) begin
                msb_first_reg <= cfg_data[0];
            end else if (cfg_index == lpfp_pkg::CFG_FILE_COMMAND) begin
                file_command_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_accept) begin
            m_valid_next = res_valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.data_byte, m_res_reg.command};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

endmodule
`default_nettype wire

### tb/sv/frame_parse_checker.sv
// Checker for the frame parser: predicts each output word from the accepted bytes and compares.
module frame_parse_checker
    import lpfp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [15:0]            m_tdata,   // [7:0] command, [15:8] data_byte
    input  wire logic [KIND_W-1:0]      m_tuser,   // [1:0] kind
    input  wire logic                   m_tlast,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    output int unsigned                 fail_count,
    output int unsigned                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] PHASE_CMD     = 3'(LENGTH_BYTES_DEF);
    localparam logic [2:0] PHASE_PAYLOAD = PHASE_CMD + 3'd1;

    // predicted parser state and registers
    logic [2:0]        phase;
    logic [31:0]       len_acc;
    logic [BYTE_W-1:0] cur_cmd;
    logic [31:0]       bytes_left;
    logic              file_mode;
    logic              msb_first;
    logic [BYTE_W-1:0] file_cmd;

    result_t expected_words[$];
    int unsigned mismatches;

    task automatic parse_byte(input logic [7:0] b);
        result_t r;
        if (phase > PHASE_PAYLOAD) phase = '0;
        if (phase < PHASE_CMD) begin
            if (phase == '0) len_acc = '0;
            if (msb_first) len_acc = {len_acc[23:0], b};
            else len_acc = len_acc | (32'(b) << (8 * phase[1:0]));
            phase = phase + 3'd1;
        end else if (phase == PHASE_CMD) begin
            cur_cmd   = b;
            file_mode = (b == file_cmd);
            if (len_acc <= 32'd1) begin
                // no payload: one empty marker, even for a file frame
                r.kind      = KIND_EMPTY;
                r.command   = b;
                r.data_byte = '0;
                r.last      = 1'b1;
                expected_words.push_back(r);
                bytes_left = '0;
                file_mode  = 1'b0;
                phase      = '0;
            end else begin
                bytes_left = len_acc - 32'd1;
                phase      = PHASE_PAYLOAD;
            end
        end else begin
            r.kind      = file_mode ? KIND_FILE : KIND_MSG;
            r.command   = cur_cmd;
            r.data_byte = b;
            r.last      = (bytes_left <= 32'd1);
            expected_words.push_back(r);
            if (r.last) begin
                bytes_left = '0;
                file_mode  = 1'b0;
                phase      = '0;
            end else begin
                bytes_left = bytes_left - 32'd1;
            end
        end
    endtask

    task automatic compare_word();
        result_t want;
        if (expected_words.size() == 0) begin
            $error("output word with nothing expected: kind %0d command %0d data %0d last %0d",
                   m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
            mismatches++;
            return;
        end
        want = expected_words.pop_front();
        if (m_tuser !== want.kind) begin
            $error("kind expected %0d got %0d", want.kind, m_tuser);
            mismatches++;
        end
        if (m_tdata[7:0] !== want.command) begin
            $error("command expected %0d got %0d", want.command, m_tdata[7:0]);
            mismatches++;
        end
        if (m_tdata[15:8] !== want.data_byte) begin
            $error("data_byte expected %0d got %0d", want.data_byte, m_tdata[15:8]);
            mismatches++;
        end
        if (m_tlast !== want.last) begin
            $error("last expected %0d got %0d", want.last, m_tlast);
            mismatches++;
        end
    endtask

    initial begin
        mismatches  = 0;
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase      = '0;
            len_acc    = '0;
            cur_cmd    = '0;
            bytes_left = '0;
            file_mode  = 1'b0;
            msb_first  = 1'b1;
            file_cmd   = FILE_COMMAND_RST;
            expected_words.delete();
        end else begin
            // a word leaving now was produced at an earlier edge, so pop before push
            if (m_tvalid && m_tready) compare_word();
            if (s_tvalid && s_tready) parse_byte(s_tdata);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MSB_FIRST) msb_first = cfg_data[0];
                else if (cfg_index == CFG_FILE_COMMAND) file_cmd = cfg_data;
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_words.size();
    end

endmodule

### tb/sv/tb.sv
// Testbench top: clock, reset, byte stream and register stimulus, and the final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpfp_pkg::*;

    localparam int unsigned RUN_LIMIT    = 400_000;
    localparam int unsigned RANDOM_BYTES = 1450;
    localparam int unsigned SETTLE_CYC   = 4;

    // indices with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    bit          no_idle;
    logic        cur_msb;
    logic [7:0]  cur_file_cmd;

    length_prefixed_frame_parser_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_parse_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // sink side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= no_idle || ($urandom_range(99) >= 33);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("length_prefixed_frame_parser_unit: mismatch");
            $finish;
        end
    end

    // valid is only dropped when a gap is taken, so back-to-back bytes keep it high
    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] len);
        for (int i = 0; i < LENGTH_BYTES_DEF; i++) begin
            if (cur_msb) send_byte(8'(len >> (8 * (LENGTH_BYTES_DEF - 1 - i))));
            else send_byte(8'(len >> (8 * i)));
        end
    endtask

    task automatic send_frame(input logic [31:0] len, input logic [7:0] cmd);
        send_header(len);
        send_byte(cmd);
        for (int unsigned n = 1; n < len; n++) send_byte(8'($urandom));
    endtask

    // stop sending and let every predicted word drain out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_MSB_FIRST) cur_msb = val[0];
        else if (idx == CFG_FILE_COMMAND) cur_file_cmd = val;
    endtask

    initial begin
        int unsigned pick;
        int unsigned next_reconfig;
        logic [31:0] len;
        logic [7:0]  cmd;

        cycle_count   = 0;
        bytes_sent    = 0;
        no_idle       = 1'b0;
        cur_msb       = 1'b1;
        cur_file_cmd  = FILE_COMMAND_RST;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty frames, file frame, register extremes, mid-frame changes
        send_header(32'd1);
        send_byte(8'h00);
        send_header(32'd0);
        send_byte(FILE_COMMAND_RST);
        send_header(32'd3);
        send_byte(FILE_COMMAND_RST);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();
        write_reg(CFG_MSB_FIRST, 8'h00);
        write_reg(CFG_FILE_COMMAND, 8'hFF);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h01);
        send_header(32'd3);
        send_byte(8'hFF);
        send_byte(8'hAA);
        drain();
        // command was latched at the command byte, so this stays a file word
        write_reg(CFG_FILE_COMMAND, 8'h00);
        send_byte(8'h55);
        // byte order flipped half way through the length
        send_byte(8'h00);
        send_byte(8'h00);
        drain();
        write_reg(CFG_MSB_FIRST, 8'h01);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h7F);
        send_byte(8'h80);
        drain();

        // random frames, mostly short, the odd long one
        bytes_sent    = 0;
        next_reconfig = $urandom_range(100, 250);
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= next_reconfig) begin
                drain();
                write_reg(CFG_MSB_FIRST, 8'($urandom));
                pick = $urandom_range(99);
                if (pick < 20) write_reg(CFG_FILE_COMMAND, FILE_COMMAND_RST);
                else if (pick < 30) write_reg(CFG_FILE_COMMAND, 8'h00);
                else if (pick < 40) write_reg(CFG_FILE_COMMAND, 8'hFF);
                else write_reg(CFG_FILE_COMMAND, 8'($urandom));
                if ($urandom_range(3) == 0)
                    write_reg(2'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));
                next_reconfig = bytes_sent + $urandom_range(100, 250);
            end
            no_idle = (bytes_sent >= 600 && bytes_sent < 850);
            pick = $urandom_range(99);
            if (pick < 8) len = 32'($urandom_range(1));
            else if (pick < 90) len = 32'($urandom_range(2, 10));
            else if (pick < 98) len = 32'($urandom_range(11, 64));
            else len = 32'($urandom_range(250, 300));
            cmd = ($urandom_range(99) < 35) ? cur_file_cmd : 8'($urandom);
            send_frame(len, cmd);
        end
        no_idle = 1'b0;

        drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("length_prefixed_frame_parser_unit: match");
        end else begin
            $display("length_prefixed_frame_parser_unit: mismatch");
        end
        $finish;
    end

endmodule
